@@ design/lmrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lmrs_pkg
// Types and constants shared by the lane-masked register scoreboard.
// ----------------------------------------------------------------------------
package lmrs_pkg;

    localparam int WARPS_DEF = 32;
    localparam int REGS_DEF  = 64;
    localparam int LANES_DEF = 32;

    // fixed field widths of the command and result items
    localparam int WARP_W = 5;
    localparam int REG_W  = 6;
    localparam int MASK_W = 32;
    // widest entry index that the warp and register fields can reach
    localparam int IDX_W  = WARP_W + REG_W;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CHECK   = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVERLAP    = 2'd1,
        ST_UNRESERVED = 2'd2
    } status_t;

    typedef struct packed {
        op_t               operation;
        logic [WARP_W-1:0] warp;
        logic [REG_W-1:0]  register_req;
        logic [MASK_W-1:0] lane_mask;
        logic              long_load;
        logic              last_of_check;
    } in_item_t;

    typedef struct packed {
        status_t status;
        logic    collision;
        logic    pending;
        logic    long_op;
    } out_item_t;

    // classified item handed from the front to the back
    typedef struct packed {
        op_t               operation;
        logic [WARP_W-1:0] warp;
        logic              warp_ok;
        logic              entry_ok;
        logic [IDX_W-1:0]  idx;
        logic [MASK_W-1:0] mask;
        logic              long_load;
        logic              last;
    } work_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

endpackage

@@ design/lmrs_front.sv @@
// ----------------------------------------------------------------------------
// lmrs_front
// Accepts command items, works out entry index and validity, and queues them.
// ----------------------------------------------------------------------------
module lmrs_front
    import lmrs_pkg::*;
#(
    parameter int WARPS = WARPS_DEF,
    parameter int REGS  = REGS_DEF,
    parameter int LANES = LANES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  cmd,
    input  back_ctl_t ctl,
    output logic      q_valid,
    output work_t     q_item
);

    // only warps and registers that the fields can name take up storage
    localparam int WE   = (WARPS < (1 << WARP_W)) ? WARPS : (1 << WARP_W);
    localparam int RE   = (REGS < (1 << REG_W)) ? REGS : (1 << REG_W);
    localparam int LW   = (LANES < MASK_W) ? LANES : MASK_W;
    localparam logic [MASK_W-1:0] LANE_KEEP = MASK_W'((64'd1 << LW) - 64'd1);
    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    work_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             push;
    logic             warp_ok;
    logic             reg_ok;
    int               idx_full;
    work_t            work;

    always_comb
    begin
        warp_ok  = int'(cmd.warp) < WE;
        reg_ok   = (cmd.register_req != '0) && (int'(cmd.register_req) < RE);
        idx_full = int'(cmd.warp) * RE + int'(cmd.register_req);

        work.operation = cmd.operation;
        work.warp      = cmd.warp;
        work.warp_ok   = warp_ok;
        work.entry_ok  = warp_ok && reg_ok;
        work.idx       = (warp_ok && reg_ok) ? IDX_W'(idx_full) : '0;
        work.mask      = cmd.lane_mask & LANE_KEEP;
        work.long_load = cmd.long_load;
        work.last      = cmd.last_of_check;
    end

    assign busy    = (count_reg == CNTW'(QUEUE_DEPTH)) || ctl.clearing;
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, ctl.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= work;
        end
    end

endmodule

@@ design/lmrs_back.sv @@
// ----------------------------------------------------------------------------
// lmrs_back
// Lane-mask store, per-warp pending counts and check fold; runs one item at
// a time as a read then a read-modify-write.
// ----------------------------------------------------------------------------
module lmrs_back
    import lmrs_pkg::*;
#(
    parameter int WARPS = WARPS_DEF,
    parameter int REGS  = REGS_DEF,
    parameter int LANES = LANES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  work_t     q_item,
    output back_ctl_t ctl,
    output logic      done,
    output out_item_t result
);

    localparam int WE    = (WARPS < (1 << WARP_W)) ? WARPS : (1 << WARP_W);
    localparam int RE    = (REGS < (1 << REG_W)) ? REGS : (1 << REG_W);
    localparam int LW    = (LANES < MASK_W) ? LANES : MASK_W;
    localparam int DEPTH = WE * RE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(RE + 1);
    localparam int WIW   = (WE > 1) ? $clog2(WE) : 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    work_t            cur_reg;
    logic [LW:0]      rd_reg;
    logic [LW:0]      lanes_mem [DEPTH];
    logic [CW-1:0]    pcount_reg [WE];
    logic             hit_reg, hit_next;
    out_item_t        result_reg, result_next;
    logic             done_reg, done_next;

    logic             pop;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [LW:0]      mem_wdata;
    logic [LW-1:0]    old_lanes;
    logic             old_long;
    logic [LW-1:0]    m;
    logic [LW-1:0]    new_lanes;
    logic [WIW-1:0]   wsel;
    logic [CW-1:0]    pc_cur;
    logic             pc_we;
    logic [CW-1:0]    pc_sel_next;
    logic             hit;

    assign pop          = (state_reg == S_IDLE) && q_valid;
    assign ctl.pop      = pop;
    assign ctl.clearing = (state_reg == S_CLEAR);
    assign done         = done_reg;
    assign result       = result_reg;

    assign old_lanes = rd_reg[LW-1:0];
    assign old_long  = rd_reg[LW];
    assign m         = cur_reg.mask[LW-1:0];
    assign wsel      = cur_reg.warp[WIW-1:0];
    assign pc_cur    = pcount_reg[wsel];
    assign hit       = cur_reg.entry_ok && ((old_lanes & m) != '0);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        hit_next    = hit_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = cur_reg.idx[AW-1:0];
        mem_wdata   = rd_reg;
        new_lanes   = old_lanes;
        pc_we       = 1'b0;
        pc_sel_next = pc_cur;
        result_next = '{status: ST_OK, collision: 1'b0, pending: 1'b0, long_op: 1'b0};

        case (state_reg)
            S_CLEAR:
            begin
                // sweep the store to zero after reset
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (cur_reg.operation)
                    OP_RESERVE:
                    begin
                        if (cur_reg.entry_ok)
                        begin
                            if ((old_lanes & m) != '0)
                            begin
                                result_next.status = ST_OVERLAP;
                            end
                            else if (m != '0)
                            begin
                                new_lanes = old_lanes | m;
                                mem_we    = 1'b1;
                                mem_wdata = {old_long | cur_reg.long_load, new_lanes};
                                if (old_lanes == '0)
                                begin
                                    pc_we       = 1'b1;
                                    pc_sel_next = pc_cur + 1'b1;
                                end
                            end
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (cur_reg.entry_ok && (old_lanes != '0))
                        begin
                            if ((m & ~old_lanes) != '0)
                            begin
                                result_next.status = ST_UNRESERVED;
                            end
                            else
                            begin
                                new_lanes = old_lanes & ~m;
                                mem_we    = 1'b1;
                                mem_wdata = {1'b0, new_lanes};
                                if ((new_lanes == '0) && (pc_cur != '0))
                                begin
                                    pc_we       = 1'b1;
                                    pc_sel_next = pc_cur - 1'b1;
                                end
                            end
                        end
                    end
                    OP_CHECK:
                    begin
                        if (cur_reg.last)
                        begin
                            result_next.collision = hit_reg | hit;
                            hit_next              = 1'b0;
                        end
                        else
                        begin
                            hit_next = hit_reg | hit;
                        end
                    end
                    OP_QUERY:
                    begin
                        result_next.pending = cur_reg.warp_ok && (pc_cur != '0);
                        result_next.long_op = cur_reg.entry_ok && old_long;
                    end
                    default:
                    begin
                        result_next = result_next;
                    end
                endcase
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
            for (int i = 0; i < WE; i++)
            begin
                pcount_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
            if (pc_we)
            begin
                pcount_reg[wsel] <= pc_sel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (pop)
        begin
            cur_reg <= q_item;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lanes_mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rd_reg <= lanes_mem[q_item.idx[AW-1:0]];
        end
    end

    // a result only ever follows the execution state
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC))
        else $error("result without execution");

    // nothing leaves the queue while the store is being swept
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !pop && !mem_we || (mem_waddr == clr_reg))
        else $error("queue popped or stray write during clear");

    // error status only from reserve and release
    a_status_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (result_reg.status != ST_OK) |->
            (cur_reg.operation == OP_RESERVE) || (cur_reg.operation == OP_RELEASE))
        else $error("error status from check or query");

    // collision only reported on the closing item of a check run
    a_coll_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.collision |->
            (cur_reg.operation == OP_CHECK) && cur_reg.last)
        else $error("collision outside closing check item");

    // a closed check run leaves the fold clear
    a_hit_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && (cur_reg.operation == OP_CHECK) && cur_reg.last
            |=> !hit_reg)
        else $error("check fold not cleared");

endmodule

@@ design/lane_masked_register_scoreboard.sv @@
// ----------------------------------------------------------------------------
// lane_masked_register_scoreboard
// Per-warp scoreboard of pending register writes kept as lane masks.
// ----------------------------------------------------------------------------
// After reset the block sweeps its lane-mask store to zero, one entry a cycle,
// over WARPS*REGS entries (2048 at the defaults; warps beyond 32 and registers
// beyond 64 cannot be named and take no storage); busy stays high meanwhile.
// Each accepted item then runs as a store read followed by a
// read-modify-write, and its result is registered onto result with done
// high for one cycle. A two-entry queue lets start be taken while earlier
// items execute; busy rises when it is full. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module lane_masked_register_scoreboard
    import lmrs_pkg::*;
#(
    parameter int WARPS = WARPS_DEF,
    parameter int REGS  = REGS_DEF,
    parameter int LANES = LANES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  cmd,
    output logic      done,
    output out_item_t result
);

    back_ctl_t ctl;
    logic      q_valid;
    work_t     q_item;

    lmrs_front #(
        .WARPS (WARPS),
        .REGS  (REGS),
        .LANES (LANES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .ctl     (ctl),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    lmrs_back #(
        .WARPS (WARPS),
        .REGS  (REGS),
        .LANES (LANES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .ctl     (ctl),
        .done    (done),
        .result  (result)
    );

endmodule
